// ===== rtl/tga_pkg.sv =====
// ----------------------------------------------------------------------------
// tga_pkg
// Shared types, status codes and channel scaling for the TGA decoder.
// ----------------------------------------------------------------------------
package tga_pkg;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_TRUNC = 3'd1;
  localparam logic [2:0] ST_SIZE  = 3'd2;
  localparam logic [2:0] ST_TYPE  = 3'd3;
  localparam logic [2:0] ST_DEPTH = 3'd4;
  localparam logic [2:0] ST_BLANK = 3'd5;

  typedef enum logic [2:0] {
    DEPTH_GREY,
    DEPTH_555,
    DEPTH_565,
    DEPTH_BGR,
    DEPTH_BGRA
  } depth_e;

  typedef struct packed {
    logic        has_pix;
    logic        has_st;
    logic [27:0] addr;
    logic [31:0] raw;
    depth_e      depth;
    logic [2:0]  status;
    logic [15:0] width;
    logic [15:0] height;
  } entry_t;

  // floor(v * 255 / 31) or floor(v * 255 / 63) by reciprocal and one correction
  function automatic logic [7:0] scale_chan(input logic [5:0] v, input logic six);
    logic [13:0] x;
    logic [11:0] k;
    logic [5:0]  m;
    logic [25:0] p;
    logic [7:0]  q;
    logic [13:0] r;
    x = 14'(v) * 14'd255;
    k = six ? 12'd1040 : 12'd2114;
    m = six ? 6'd63 : 6'd31;
    p = 26'(x) * 26'(k);
    q = p[23:16];
    r = x - 14'(q) * 14'(m);
    if (r >= 14'(m)) begin
      q = q + 8'd1;
    end
    return q;
  endfunction

endpackage

// ===== rtl/tga_front.sv =====
// ----------------------------------------------------------------------------
// tga_front
// Byte parser: header, skip, size/type/depth checks and pixel assembly.
// ----------------------------------------------------------------------------
module tga_front #(
  parameter int MAX_SIDE = 16384
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      byte_i,
  input  logic            eof_i,
  input  logic [15:0]     limit_i,
  output logic            push_o,
  output tga_pkg::entry_t entry_o
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_PIXELS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;
  localparam logic [15:0] MaxSide  = 16'(MAX_SIDE);

  logic [1:0]  phase_q, phase_d;
  logic [4:0]  hdr_q, hdr_d;
  logic [21:0] skip_q, skip_d;
  logic [1:0]  pcnt_q, pcnt_d;
  logic [23:0] pbytes_q, pbytes_d;
  logic [7:0]  id_q, id_d, type_q, type_d, bits_q, bits_d, depth_q, depth_d;
  logic        cm_q, cm_d, fx_q, fx_d, fy_q, fy_d;
  logic [15:0] cml_q, cml_d, w_q, w_d, h_q, h_d, row_q, row_d, col_q, col_d;
  logic [27:0] base_q, base_d;

  logic [15:0] lim;
  logic [21:0] skip_len;
  logic [27:0] prod;
  logic        dec_fy;
  logic [2:0]  dec_st;
  logic        dec_pix;
  logic [1:0]  bpp_m1;
  logic [31:0] raw;
  logic [15:0] out_col;
  tga_pkg::depth_e dcode;

  assign lim      = (limit_i < MaxSide) ? limit_i : MaxSide;
  assign skip_len = 22'(id_q) + (cm_q ? 22'(6'((9'(bits_q) + 9'd7) >> 3)) * 22'(cml_q) : 22'd0);
  assign prod     = 28'(32'(h_q - 16'd1) * 32'(w_q));
  assign dec_fy   = (phase_q == PH_HEADER) ? byte_i[5] : fy_q;

  always_comb begin
    dec_pix = 1'b0;
    dec_st  = tga_pkg::ST_BLANK;
    if (w_q > lim || h_q > lim || w_q == 16'd0 || h_q == 16'd0) begin
      dec_st = tga_pkg::ST_SIZE;
    end else if (type_q == 8'd1 || type_q == 8'd9 || type_q == 8'd10 || type_q == 8'd11) begin
      dec_st = tga_pkg::ST_TYPE;
    end else if (type_q == 8'd2 || type_q == 8'd3) begin
      if (depth_q == 8'd8 || depth_q == 8'd15 || depth_q == 8'd16 ||
          depth_q == 8'd24 || depth_q == 8'd32) begin
        dec_pix = 1'b1;
      end else begin
        dec_st = tga_pkg::ST_DEPTH;
      end
    end
  end

  always_comb begin
    case (depth_q)
      8'd8:    begin bpp_m1 = 2'd0; dcode = tga_pkg::DEPTH_GREY; end
      8'd15:   begin bpp_m1 = 2'd1; dcode = tga_pkg::DEPTH_555;  end
      8'd16:   begin bpp_m1 = 2'd1; dcode = tga_pkg::DEPTH_565;  end
      8'd24:   begin bpp_m1 = 2'd2; dcode = tga_pkg::DEPTH_BGR;  end
      default: begin bpp_m1 = 2'd3; dcode = tga_pkg::DEPTH_BGRA; end
    endcase
  end

  assign raw     = {8'd0, pbytes_q} | (32'(byte_i) << {pcnt_q, 3'd0});
  assign out_col = fx_q ? (w_q - 16'd1 - col_q) : col_q;

  always_comb begin
    phase_d = phase_q; hdr_d = hdr_q; skip_d = skip_q; pcnt_d = pcnt_q; pbytes_d = pbytes_q;
    id_d = id_q; type_d = type_q; bits_d = bits_q; depth_d = depth_q; cm_d = cm_q;
    fx_d = fx_q; fy_d = fy_q; cml_d = cml_q; w_d = w_q; h_d = h_q;
    row_d = row_q; col_d = col_q; base_d = base_q;
    entry_o         = '0;
    entry_o.addr    = base_q + 28'(out_col);
    entry_o.raw     = raw;
    entry_o.depth   = dcode;
    push_o          = 1'b0;
    if (fire_i) begin
      case (phase_q)
        PH_HEADER: begin
          hdr_d = hdr_q + 5'd1;
          case (hdr_q)
            5'd0:  id_d = byte_i;
            5'd1:  cm_d = (byte_i != 8'd0);
            5'd2:  type_d = byte_i;
            5'd5:  cml_d = {cml_q[15:8], byte_i};
            5'd6:  cml_d = {byte_i, cml_q[7:0]};
            5'd7:  bits_d = byte_i;
            5'd12: w_d = {w_q[15:8], byte_i};
            5'd13: w_d = {byte_i, w_q[7:0]};
            5'd14: h_d = {h_q[15:8], byte_i};
            5'd15: h_d = {byte_i, h_q[7:0]};
            5'd16: depth_d = byte_i;
            5'd17: begin fx_d = byte_i[4]; fy_d = byte_i[5]; end
            default: ;
          endcase
          if (hdr_q == 5'd17) begin
            if (skip_len != 22'd0) begin
              phase_d = PH_SKIP;
              skip_d  = skip_len;
            end else begin
              phase_d = PH_DONE;
            end
          end
        end
        PH_SKIP: begin
          skip_d = skip_q - 22'd1;
          if (skip_q == 22'd1) phase_d = PH_DONE;
        end
        PH_PIXELS: begin
          entry_o.has_pix = (pcnt_q == bpp_m1);
          push_o          = entry_o.has_pix;
          pcnt_d          = pcnt_q + 2'd1;
          pbytes_d        = raw[23:0];
          if (pcnt_q == bpp_m1) begin
            pcnt_d   = 2'd0;
            pbytes_d = '0;
            col_d    = col_q + 16'd1;
            if (col_d >= w_q) begin
              col_d  = '0;
              row_d  = row_q + 16'd1;
              base_d = fy_q ? base_q + 28'(w_q) : base_q - 28'(w_q);
              if (row_d >= h_q) begin
                phase_d        = PH_DONE;
                entry_o.has_st = 1'b1;
                entry_o.status = tga_pkg::ST_OK;
                entry_o.width  = w_q;
                entry_o.height = h_q;
              end
            end
          end
        end
        default: ;
      endcase
      // header or skip just ended: run the checks
      if (phase_d == PH_DONE && phase_q != PH_DONE && phase_q != PH_PIXELS) begin
        if (dec_pix) begin
          phase_d  = PH_PIXELS;
          pcnt_d   = '0;
          pbytes_d = '0;
          row_d    = '0;
          col_d    = '0;
          base_d   = dec_fy ? 28'd0 : prod;
        end else begin
          entry_o.has_st = 1'b1;
          entry_o.status = dec_st;
          if (dec_st == tga_pkg::ST_BLANK) begin
            entry_o.width  = w_q;
            entry_o.height = h_q;
          end
        end
      end
      if (eof_i) begin
        if (phase_d != PH_DONE) begin
          entry_o.has_st = 1'b1;
          entry_o.status = tga_pkg::ST_TRUNC;
          entry_o.width  = '0;
          entry_o.height = '0;
        end
        phase_d  = PH_HEADER;
        hdr_d    = '0;
        pcnt_d   = '0;
        pbytes_d = '0;
      end
      push_o = entry_o.has_pix | entry_o.has_st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      hdr_q    <= '0;
      pcnt_q   <= '0;
      pbytes_q <= '0;
    end else begin
      phase_q  <= phase_d;
      hdr_q    <= hdr_d;
      pcnt_q   <= pcnt_d;
      pbytes_q <= pbytes_d;
    end
  end

  always_ff @(posedge clk_i) begin
    skip_q <= skip_d; id_q <= id_d; type_q <= type_d; bits_q <= bits_d; depth_q <= depth_d;
    cm_q <= cm_d; fx_q <= fx_d; fy_q <= fy_d; cml_q <= cml_d; w_q <= w_d; h_q <= h_d;
    row_q <= row_d; col_q <= col_d; base_q <= base_d;
  end

endmodule

// ===== rtl/tga_fifo.sv =====
// ----------------------------------------------------------------------------
// tga_fifo
// Four-entry queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module tga_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tga_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            nempty_o,
  output tga_pkg::entry_t head_o
);

  tga_pkg::entry_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  assign full_o   = (cnt_q == 3'd4);
  assign nempty_o = (cnt_q != 3'd0);
  assign head_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 2'd1;
      if (pop_i) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= entry_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> nempty_o) else $error("pop from empty queue");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 3'd1) else $error("count slip");

endmodule

// ===== rtl/tga_back.sv =====
// ----------------------------------------------------------------------------
// tga_back
// Output stage: converts pixels to RGBA and emits writes and status.
// ----------------------------------------------------------------------------
module tga_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            nempty_i,
  input  tga_pkg::entry_t head_i,
  output logic            pop_o,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [95:0]     m_axis_tdata,
  output logic            m_axis_tuser,
  output logic            m_axis_tlast
);

  logic        valid_q, sel_q, sel_d, load;
  logic [95:0] data_q, data_d;
  logic        kind_q, kind_d;
  logic [31:0] rgba;
  logic [7:0]  r, g, b, a;

  always_comb begin
    a = 8'd255;
    case (head_i.depth)
      tga_pkg::DEPTH_BGRA: begin
        b = head_i.raw[7:0]; g = head_i.raw[15:8]; r = head_i.raw[23:16]; a = head_i.raw[31:24];
      end
      tga_pkg::DEPTH_BGR: begin
        b = head_i.raw[7:0]; g = head_i.raw[15:8]; r = head_i.raw[23:16];
      end
      tga_pkg::DEPTH_565: begin
        b = tga_pkg::scale_chan({1'b0, head_i.raw[4:0]}, 1'b0);
        g = tga_pkg::scale_chan(head_i.raw[10:5], 1'b1);
        r = tga_pkg::scale_chan({1'b0, head_i.raw[15:11]}, 1'b0);
      end
      tga_pkg::DEPTH_555: begin
        b = tga_pkg::scale_chan({1'b0, head_i.raw[4:0]}, 1'b0);
        g = tga_pkg::scale_chan({1'b0, head_i.raw[9:5]}, 1'b0);
        r = tga_pkg::scale_chan({1'b0, head_i.raw[14:10]}, 1'b0);
      end
      default: begin
        r = head_i.raw[7:0]; g = head_i.raw[7:0]; b = head_i.raw[7:0];
      end
    endcase
  end
  assign rgba = {a, b, g, r};

  assign load = nempty_i && (!valid_q || m_axis_tready);

  always_comb begin
    sel_d  = sel_q;
    pop_o  = 1'b0;
    kind_d = kind_q;
    data_d = data_q;
    if (load) begin
      if (head_i.has_pix && !sel_q) begin
        kind_d = 1'b0;
        data_d = {36'd0, rgba, head_i.addr};
        if (head_i.has_st) begin
          sel_d = 1'b1;
        end else begin
          pop_o = 1'b1;
        end
      end else begin
        kind_d = 1'b1;
        data_d = {1'b0, head_i.height, head_i.width, head_i.status, 60'd0};
        sel_d  = 1'b0;
        pop_o  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      sel_q <= sel_d;
      if (load) valid_q <= 1'b1;
      else if (m_axis_tready) valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    kind_q <= kind_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = kind_q;

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> nempty_i) else $error("status half lost its entry");
  a_status_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && sel_q) |-> pop_o) else $error("status half did not pop");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !m_axis_tready) |=> $stable(data_q)) else $error("result changed while held");

endmodule

// ===== rtl/tga_uncompressed_decoder.sv =====
// ----------------------------------------------------------------------------
// tga_uncompressed_decoder
// Streaming uncompressed TGA decoder: bytes in, RGBA writes and status out.
// Throughput: one byte per cycle while the queue has room; a byte closing a pixel
// plus status yields two output transfers, drained by a four-entry queue.
// Each result is written into the queue, then into the output register.
// Reset clears control state; size_limit returns to MAX_SIDE.
// ----------------------------------------------------------------------------
module tga_uncompressed_decoder #(
  parameter int MAX_SIDE = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // end_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // pixel_address, rgba, status, width, height
  output logic        m_axis_tuser,   // kind
  output logic        m_axis_tlast,   // last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i
);

  logic [15:0] limit_q;
  logic        full, nempty, push, pop;
  tga_pkg::entry_t entry, head;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 16'(MAX_SIDE);
    end else if (cfg_valid_i) begin
      limit_q <= {1'b0, cfg_data_i};
    end
  end

  tga_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk_i, .rst_ni,
    .fire_i  (s_axis_tvalid && s_axis_tready),
    .byte_i  (s_axis_tdata),
    .eof_i   (s_axis_tlast),
    .limit_i (limit_q),
    .push_o  (push),
    .entry_o (entry)
  );

  tga_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i   (push),
    .entry_i  (entry),
    .full_o   (full),
    .pop_i    (pop),
    .nempty_o (nempty),
    .head_o   (head)
  );

  tga_back u_back (
    .clk_i, .rst_ni,
    .nempty_i (nempty),
    .head_i   (head),
    .pop_o    (pop),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

endmodule

// ===== tb/tga_decoder_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_decoder_checker
// Watches the byte, result and register channels of the TGA decoder, keeps
// its own copy of the parser state, predicts every pixel write and status,
// and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tga_decoder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [95:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int unsigned MAX_SIDE = 16384;

  typedef enum logic [1:0] {P_HEADER, P_SKIP, P_PIXELS, P_DONE} parse_e;

  typedef struct packed {
    logic        kind;
    logic [27:0] addr;
    logic [31:0] rgba;
    logic [2:0]  status;
    logic [15:0] width;
    logic [15:0] height;
    logic        last;
  } tga_result_t;

  tga_result_t result_q[$];

  logic [14:0] limit_reg;
  parse_e      ph;
  int unsigned cnt, id_len, cmap_on, cmap_len, cmap_bits, img_type;
  int unsigned img_w, img_h, depth, flip_x, flip_y, pix_acc, row, col, row_base;

  task automatic clear_file();
    ph = P_HEADER;
    cnt = 0; id_len = 0; cmap_on = 0; cmap_len = 0; cmap_bits = 0; img_type = 0;
    img_w = 0; img_h = 0; depth = 0; flip_x = 0; flip_y = 0; pix_acc = 0;
    row = 0; col = 0; row_base = 0;
  endtask

  task automatic push_status(input logic [2:0] st);
    tga_result_t r;
    logic sized;
    sized = (st == tga_pkg::ST_OK) || (st == tga_pkg::ST_BLANK);
    r = '0;
    r.kind = 1'b1;
    r.status = st;
    r.width = sized ? img_w[15:0] : 16'd0;
    r.height = sized ? img_h[15:0] : 16'd0;
    r.last = 1'b1;
    result_q.push_back(r);
    ph = P_DONE;
  endtask

  task automatic load_row_base();
    longint unsigned out_row;
    out_row = flip_y ? row : ((img_h - 1 - row) & 32'hFFFF);
    row_base = (out_row * img_w) & 32'hFFF_FFFF;
  endtask

  task automatic classify();
    int unsigned lim;
    lim = (limit_reg < MAX_SIDE) ? limit_reg : MAX_SIDE;
    if (img_w > lim || img_h > lim || img_w == 0 || img_h == 0) begin
      push_status(tga_pkg::ST_SIZE);
    end else if (img_type inside {1, 9, 10, 11}) begin
      push_status(tga_pkg::ST_TYPE);
    end else if (img_type == 2 || img_type == 3) begin
      if (!(depth inside {8, 15, 16, 24, 32})) begin
        push_status(tga_pkg::ST_DEPTH);
      end else begin
        ph = P_PIXELS;
        cnt = 0; pix_acc = 0; row = 0; col = 0;
        load_row_base();
      end
    end else begin
      push_status(tga_pkg::ST_BLANK);
    end
  endtask

  function automatic logic [31:0] expand_pixel(input int unsigned raw);
    int unsigned r, g, b, a;
    a = 255;
    case (depth)
      32: begin
        b = raw & 255; g = (raw >> 8) & 255; r = (raw >> 16) & 255; a = (raw >> 24) & 255;
      end
      24: begin
        b = raw & 255; g = (raw >> 8) & 255; r = (raw >> 16) & 255;
      end
      16: begin
        b = ((raw & 31) * 255) / 31;
        g = (((raw >> 5) & 63) * 255) / 63;
        r = (((raw >> 11) & 31) * 255) / 31;
      end
      15: begin
        b = ((raw & 31) * 255) / 31;
        g = (((raw >> 5) & 31) * 255) / 31;
        r = (((raw >> 10) & 31) * 255) / 31;
      end
      default: begin
        r = raw & 255; g = r; b = r;
      end
    endcase
    return {a[7:0], b[7:0], g[7:0], r[7:0]};
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic eof);
    int unsigned skip, bpp, raw, out_col;
    tga_result_t r;
    case (ph)
      P_HEADER: begin
        case (cnt)
          0: id_len = b;
          1: cmap_on = (b != 0);
          2: img_type = b;
          5: cmap_len = (cmap_len & 32'hFF00) | b;
          6: cmap_len = (cmap_len & 32'h00FF) | (b << 8);
          7: cmap_bits = b;
          12: img_w = (img_w & 32'hFF00) | b;
          13: img_w = (img_w & 32'h00FF) | (b << 8);
          14: img_h = (img_h & 32'hFF00) | b;
          15: img_h = (img_h & 32'h00FF) | (b << 8);
          16: depth = b;
          17: begin
            flip_x = b[4];
            flip_y = b[5];
          end
          default: ;
        endcase
        cnt++;
        if (cnt >= 18) begin
          skip = id_len;
          if (cmap_on != 0) skip += ((cmap_bits + 7) >> 3) * cmap_len;
          if (skip == 0) begin
            classify();
          end else begin
            ph = P_SKIP;
            cnt = skip;
          end
        end
      end
      P_SKIP: begin
        cnt--;
        if (cnt == 0) classify();
      end
      P_PIXELS: begin
        bpp = (depth + 7) >> 3;
        raw = pix_acc | (int'(b) << (8 * (cnt & 3)));
        cnt++;
        if (cnt < bpp) begin
          pix_acc = raw & 32'hFF_FFFF;
        end else begin
          out_col = flip_x ? ((img_w - 1 - col) & 32'hFFFF) : col;
          r = '0;
          r.addr = 28'(row_base + out_col);
          r.rgba = expand_pixel(raw);
          result_q.push_back(r);
          cnt = 0;
          pix_acc = 0;
          col++;
          if (col >= img_w) begin
            col = 0;
            row++;
            if (row >= img_h) push_status(tga_pkg::ST_OK);
            else load_row_base();
          end
        end
      end
      default: ;
    endcase
    if (eof) begin
      if (ph != P_DONE) push_status(tga_pkg::ST_TRUNC);
      clear_file();
    end
  endtask

  task automatic compare_result();
    tga_result_t e;
    if (result_q.size() == 0) begin
      $error("unexpected result transfer tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
      fail_count_o++;
    end else begin
      e = result_q.pop_front();
      if (m_axis_tuser !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, m_axis_tuser);
        fail_count_o++;
      end
      if (m_axis_tdata[27:0] !== e.addr) begin
        $error("pixel_address: expected %0d, got %0d", e.addr, m_axis_tdata[27:0]);
        fail_count_o++;
      end
      if (m_axis_tdata[59:28] !== e.rgba) begin
        $error("rgba: expected %h, got %h", e.rgba, m_axis_tdata[59:28]);
        fail_count_o++;
      end
      if (m_axis_tdata[62:60] !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, m_axis_tdata[62:60]);
        fail_count_o++;
      end
      if (m_axis_tdata[78:63] !== e.width) begin
        $error("width: expected %0d, got %0d", e.width, m_axis_tdata[78:63]);
        fail_count_o++;
      end
      if (m_axis_tdata[94:79] !== e.height) begin
        $error("height: expected %0d, got %0d", e.height, m_axis_tdata[94:79]);
        fail_count_o++;
      end
      if (m_axis_tlast !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_reg = 15'(MAX_SIDE);
      clear_file();
      result_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) limit_reg = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) compare_result();
      pending_o = result_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives whole TGA files, directed then random, into the decoder under
// varying size limits and back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [14:0] cfg_data_i = '0;
  int          fail_count;
  int          pending;

  int          tx_idle = 12;
  int          rx_idle = 72;
  int          stall_cycles = 0;
  int          bytes_sent = 0;
  logic [8:0]  file_q[$];

  localparam int STALL_LIMIT = 20000;

  tga_uncompressed_decoder uut (.*);

  tga_decoder_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle);
  end

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles > STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic send_file();
    logic [8:0] item;
    item = file_q.pop_back();
    item[8] = 1'b1;
    file_q.push_back(item);
    while (file_q.size() > 0) begin
      item = file_q.pop_front();
      while ($urandom_range(99) < tx_idle) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= item[7:0];
      s_axis_tlast <= item[8];
      do @(posedge clk_i); while (!s_axis_tready);
      bytes_sent++;
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic push_byte(input int unsigned b);
    file_q.push_back({1'b0, b[7:0]});
  endtask

  // header, id and colour map filler, then body bytes (byte count adjusted by trim)
  task automatic build_image(input int unsigned idl, cmt, cml, ceb, typ, w, h, dep, desc,
                             input int trim, input bit max_bytes);
    int body;
    push_byte(idl); push_byte(cmt); push_byte(typ);
    push_byte(0); push_byte(0);
    push_byte(cml); push_byte(cml >> 8); push_byte(ceb);
    repeat (4) push_byte($urandom);
    push_byte(w); push_byte(w >> 8); push_byte(h); push_byte(h >> 8);
    push_byte(dep); push_byte(desc);
    repeat (idl + ((cmt != 0) ? ((ceb + 7) / 8) * cml : 0)) push_byte($urandom);
    body = (typ == 2 || typ == 3) ? int'(w * h * ((dep + 7) / 8)) : 0;
    body += trim;
    if (body > 80) body = 80;
    if (body < 1) body = 1;
    repeat (body) push_byte(max_bytes ? 255 : $urandom);
    send_file();
  endtask

  task automatic drain();
    @(posedge clk_i);
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [14:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_image();
    int unsigned typ, dep, w, h, pick;
    int trim;
    pick = $urandom_range(99);
    typ = (pick < 75) ? 2 + $urandom_range(1) : (pick < 85) ? $urandom_range(255) :
          (pick < 92) ? 1 + 8 * ($urandom_range(3) != 0) + $urandom_range(2) : 0;
    pick = $urandom_range(99);
    case ($urandom_range(4))
      0: dep = 8;
      1: dep = 15;
      2: dep = 16;
      3: dep = 24;
      default: dep = 32;
    endcase
    if (pick < 5) dep = $urandom_range(255);
    w = $urandom_range(1, 4);
    h = $urandom_range(1, 4);
    pick = $urandom_range(99);
    if (pick < 4) w = $urandom_range(65535);
    else if (pick < 8) h = 0;
    pick = $urandom_range(99);
    trim = (pick < 10) ? -int'($urandom_range(1, 6)) : (pick < 20) ? $urandom_range(1, 5) : 0;
    build_image(($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0,
                ($urandom_range(5) == 0) ? $urandom_range(1, 255) : 0,
                $urandom_range(3), $urandom_range(33), typ, w, h, dep,
                $urandom_range(255), trim, 1'b0);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every depth, flips, skips, error kinds, truncation, extra bytes
    build_image(0, 0, 0, 0, 2, 2, 2, 8, 8'h00, 0, 1'b0);
    build_image(0, 0, 0, 0, 2, 2, 2, 15, 8'h10, 0, 1'b1);
    build_image(0, 0, 0, 0, 3, 2, 1, 16, 8'h20, 0, 1'b0);
    build_image(2, 1, 2, 24, 2, 1, 2, 24, 8'h30, 0, 1'b0);
    build_image(0, 0, 0, 0, 2, 2, 2, 32, 8'hFF, 0, 1'b0);
    build_image(0, 0, 0, 0, 2, 65535, 1, 8, 0, 2, 1'b0);
    build_image(0, 0, 0, 0, 2, 16385, 1, 8, 0, 0, 1'b0);
    build_image(0, 0, 0, 0, 2, 0, 3, 8, 0, 0, 1'b0);
    build_image(0, 0, 0, 0, 1, 2, 2, 8, 0, 0, 1'b0);
    build_image(0, 0, 0, 0, 9, 2, 2, 8, 0, 0, 1'b0);
    build_image(0, 0, 0, 0, 10, 2, 2, 8, 0, 0, 1'b0);
    build_image(0, 0, 0, 0, 11, 2, 2, 8, 0, 0, 1'b0);
    build_image(0, 0, 0, 0, 0, 3, 65535, 8, 0, 0, 1'b0);
    build_image(0, 0, 0, 0, 255, 3, 4, 8, 0, 0, 1'b0);
    build_image(0, 0, 0, 0, 2, 1, 1, 7, 0, 0, 1'b0);
    build_image(0, 0, 0, 0, 2, 2, 2, 24, 0, -3, 1'b0);
    build_image(0, 0, 0, 0, 3, 1, 1, 8, 0, 4, 1'b0);
    push_byte(0);
    push_byte(255);
    send_file();

    for (int seg = 0; seg < 4; seg++) begin
      tx_idle = (seg == 0) ? 12 : (seg == 3) ? 0 : 72;
      rx_idle = (seg == 0) ? 72 : (seg == 3) ? 0 : 12;
      case (seg)
        0: write_limit(15'h7FFF);
        1: write_limit(15'd1);
        2: write_limit(15'd3);
        default: write_limit(15'($urandom_range(2, 16384)));
      endcase
      if (seg == 1) build_image(0, 0, 0, 0, 2, 1, 1, 32, 0, 0, 1'b0);
      while (bytes_sent < 120 * (seg + 1) + 520) random_image();
    end

    drain();
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
